@@ src/glm_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// glm_pkg: shared types and constants of the glyph metadata cache
// op codes, controller states, command and status bundles, record layout
// ----------------------------------------------------------------------------
package glm_pkg;

  localparam int SLOTS_DEFAULT = 16;

  localparam logic [1:0] OP_LOOKUP = 2'd0;
  localparam logic [1:0] OP_INSERT = 2'd1;
  localparam logic [1:0] OP_CLEAR  = 2'd2;

  localparam logic [31:0] STAMP_MAX = 32'hFFFF_FFFF;

  typedef enum logic [2:0] {
    S_IDLE,
    S_COMPARE,
    S_DECIDE,
    S_SCAN,
    S_EVICT,
    S_DONE
  } glm_state_t;

  // one cached glyph record
  typedef struct packed {
    logic        [7:0]  width;
    logic        [7:0]  height;
    logic        [7:0]  advance;
    logic signed [15:0] left;
    logic signed [15:0] top;
    logic        [15:0] data_length;
    logic        [31:0] data_offset;
  } glm_record_t;

  // one request transaction
  typedef struct packed {
    logic [1:0]  op;
    logic [20:0] codepoint;
    glm_record_t rec;
  } glm_item_t;

  // controller to datapath
  typedef struct packed {
    logic capture;
    logic compare;
    logic touch;
    logic write;
    logic use_victim;
    logic scan_start;
    logic scan_step;
    logic clear;
    logic respond;
  } glm_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic is_lookup;
    logic is_insert;
    logic is_clear;
    logic any_match;
    logic any_free;
    logic scan_done;
    logic out_free;
  } glm_status_t;

endpackage
`default_nettype wire

@@ src/glm_if.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// glm_if: request and response channels of the glyph metadata cache
// valid/ready handshake, payload carried beside the handshake
// ----------------------------------------------------------------------------
interface glm_req_if;
  logic               valid;
  logic               ready;
  logic        [1:0]  op;
  logic        [20:0] codepoint;
  logic        [7:0]  new_width;
  logic        [7:0]  new_height;
  logic        [7:0]  new_advance;
  logic signed [15:0] new_left;
  logic signed [15:0] new_top;
  logic        [15:0] new_data_length;
  logic        [31:0] new_data_offset;

  modport source (
    output valid, op, codepoint, new_width, new_height, new_advance,
           new_left, new_top, new_data_length, new_data_offset,
    input  ready
  );
  modport sink (
    input  valid, op, codepoint, new_width, new_height, new_advance,
           new_left, new_top, new_data_length, new_data_offset,
    output ready
  );
endinterface

interface glm_rsp_if;
  logic               valid;
  logic               ready;
  logic               hit;
  logic        [7:0]  glyph_width;
  logic        [7:0]  glyph_height;
  logic        [7:0]  glyph_advance;
  logic signed [15:0] glyph_left;
  logic signed [15:0] glyph_top;
  logic        [15:0] glyph_data_length;
  logic        [31:0] glyph_data_offset;

  modport source (
    output valid, hit, glyph_width, glyph_height, glyph_advance,
           glyph_left, glyph_top, glyph_data_length, glyph_data_offset,
    input  ready
  );
  modport sink (
    input  valid, hit, glyph_width, glyph_height, glyph_advance,
           glyph_left, glyph_top, glyph_data_length, glyph_data_offset,
    output ready
  );
endinterface
`default_nettype wire

@@ src/glm_ctrl.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// glm_ctrl: sequencing of one cache transaction
// compare, decide, optional victim scan, then hand the result to the output
// ----------------------------------------------------------------------------
module glm_ctrl
  import glm_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        req_valid,
  output logic             req_ready,
  input  wire glm_status_t status,
  output glm_cmd_t         cmd
);

  glm_state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (req_valid) state_next = S_COMPARE;
      end
      S_COMPARE: state_next = S_DECIDE;
      S_DECIDE: begin
        if (status.is_insert && !status.any_free) state_next = S_SCAN;
        else state_next = S_DONE;
      end
      S_SCAN: begin
        if (status.scan_done) state_next = S_EVICT;
      end
      S_EVICT: state_next = S_DONE;
      S_DONE: begin
        if (status.out_free) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    cmd       = '0;
    req_ready = 1'b0;
    unique case (state)
      S_IDLE: begin
        req_ready   = 1'b1;
        cmd.capture = req_valid;
      end
      S_COMPARE: cmd.compare = 1'b1;
      S_DECIDE: begin
        cmd.touch      = status.is_lookup && status.any_match;
        cmd.write      = status.is_insert && status.any_free;
        cmd.scan_start = status.is_insert && !status.any_free;
        cmd.clear      = status.is_clear;
      end
      S_SCAN: cmd.scan_step = !status.scan_done;
      S_EVICT: begin
        cmd.write      = 1'b1;
        cmd.use_victim = 1'b1;
      end
      S_DONE: cmd.respond = status.out_free;
      default: cmd = '0;
    endcase
  end

endmodule
`default_nettype wire

@@ src/glm_datapath.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// glm_datapath: tag store, record and stamp memories, victim scan, output
// register of the glyph metadata cache
// ----------------------------------------------------------------------------
module glm_datapath
  import glm_pkg::*;
#(
  parameter int SLOTS = SLOTS_DEFAULT
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire glm_cmd_t    cmd,
  output glm_status_t      status,
  input  wire glm_item_t   item,
  output logic             rsp_valid,
  input  wire logic        rsp_ready,
  output logic             rsp_hit,
  output glm_record_t      rsp_rec
);

  localparam int IDXW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int CNTW = $clog2(SLOTS + 1);
  localparam logic [CNTW-1:0] CNT_END = CNTW'(SLOTS);

  // captured transaction
  logic [1:0]  op_q;
  logic [20:0] cp_q;
  glm_record_t rec_q;

  // slot state
  logic [SLOTS-1:0] valid_q;
  logic [20:0]      tag_q [SLOTS];
  logic [31:0]      gen;
  glm_record_t      rec_mem   [SLOTS];
  logic [31:0]      stamp_mem [SLOTS];
  glm_record_t      rec_rd;
  logic [31:0]      stamp_rd;

  logic [SLOTS-1:0] match_q;
  logic [SLOTS-1:0] free_q;
  logic [IDXW-1:0]  match_idx;
  logic [IDXW-1:0]  free_idx;
  logic [IDXW-1:0]  wr_idx;
  logic             res_hit;

  // victim scan
  logic [CNTW-1:0]  rd_cnt;
  logic             issue;
  logic             cmp_vld;
  logic [IDXW-1:0]  cmp_idx;
  logic [31:0]      best_stamp;
  logic [IDXW-1:0]  best_idx;

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      op_q  <= item.op;
      cp_q  <= item.codepoint;
      rec_q <= item.rec;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.compare) begin
      for (int i = 0; i < SLOTS; i++) begin
        match_q[i] <= valid_q[i] && (tag_q[i] == cp_q);
      end
      free_q <= ~valid_q;
    end
  end

  // lowest index wins
  always_comb begin
    match_idx = '0;
    free_idx  = '0;
    for (int i = SLOTS - 1; i >= 0; i--) begin
      if (match_q[i]) match_idx = IDXW'(i);
      if (free_q[i]) free_idx = IDXW'(i);
    end
  end

  always_comb begin
    if (cmd.touch) wr_idx = match_idx;
    else if (cmd.use_victim) wr_idx = best_idx;
    else wr_idx = free_idx;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid_q <= '0;
    end else if (cmd.clear) begin
      valid_q <= '0;
    end else if (cmd.write) begin
      valid_q[wr_idx] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.write) tag_q[wr_idx] <= cp_q;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      gen <= '0;
    end else if (cmd.clear) begin
      gen <= '0;
    end else if (cmd.touch || cmd.write) begin
      gen <= gen + 32'd1;
    end
  end

  // record memory
  always_ff @(posedge clk) begin
    if (cmd.write) rec_mem[wr_idx] <= rec_q;
    if (cmd.touch) rec_rd <= rec_mem[wr_idx];
  end

  // stamp memory
  assign issue = cmd.scan_step && (rd_cnt < CNT_END);

  always_ff @(posedge clk) begin
    if (cmd.touch || cmd.write) stamp_mem[wr_idx] <= gen + 32'd1;
    if (issue) stamp_rd <= stamp_mem[rd_cnt[IDXW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_cnt  <= '0;
      cmp_vld <= 1'b0;
    end else if (cmd.scan_start) begin
      rd_cnt  <= '0;
      cmp_vld <= 1'b0;
    end else begin
      if (issue) rd_cnt <= rd_cnt + CNTW'(1);
      cmp_vld <= issue;
    end
  end

  always_ff @(posedge clk) begin
    if (issue) cmp_idx <= rd_cnt[IDXW-1:0];
    if (cmd.scan_start) begin
      best_stamp <= STAMP_MAX;
      best_idx   <= '0;
    end else if (cmp_vld && (stamp_rd < best_stamp)) begin
      best_stamp <= stamp_rd;
      best_idx   <= cmp_idx;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_hit <= 1'b0;
    end else if (cmd.capture) begin
      res_hit <= 1'b0;
    end else if (cmd.touch) begin
      res_hit <= 1'b1;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (cmd.respond) begin
      rsp_valid <= 1'b1;
    end else if (rsp_ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.respond) begin
      rsp_hit <= res_hit;
      rsp_rec <= res_hit ? rec_rd : '0;
    end
  end

  always_comb begin
    status           = '0;
    status.any_match = |match_q;
    status.any_free  = |free_q;
    status.scan_done = (rd_cnt == CNT_END) && !cmp_vld;
    status.out_free  = !rsp_valid || rsp_ready;
    unique case (op_q)
      OP_LOOKUP: status.is_lookup = 1'b1;
      OP_INSERT: status.is_insert = 1'b1;
      OP_CLEAR:  status.is_clear  = 1'b1;
      default:   status.is_lookup = 1'b0;
    endcase
  end

  a_clear_empties: assert property (@(posedge clk) disable iff (rst)
    cmd.clear |=> valid_q == '0)
    else $error("slots still valid after clear");

  a_victim_only_when_full: assert property (@(posedge clk) disable iff (rst)
    (cmd.write && cmd.use_victim) |-> (&valid_q))
    else $error("eviction while a slot was free");

  a_free_slot_is_free: assert property (@(posedge clk) disable iff (rst)
    (cmd.write && !cmd.use_victim) |-> !valid_q[free_idx])
    else $error("insert overwrote a valid slot");

  a_gen_step: assert property (@(posedge clk) disable iff (rst)
    (!$past(rst) && $past(cmd.touch || cmd.write) && !$past(cmd.clear))
      |-> gen == $past(gen) + 32'd1)
    else $error("generation did not advance by one");

  a_respond_room: assert property (@(posedge clk) disable iff (rst)
    cmd.respond |-> (!rsp_valid || rsp_ready))
    else $error("response overwrote a pending result");

endmodule
`default_nettype wire

@@ src/glyph_metadata_lru_cache.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// glyph_metadata_lru_cache: fully associative LRU cache of glyph records
// keyed by codepoint, one result transaction for every request transaction
// ----------------------------------------------------------------------------
// Each request is handled on its own and answers with exactly one result.
// A lookup, a clear, an unused op and an insert into a cache with a free
// slot go from acceptance to the result register through capture,
// parallel tag compare, priority select with the record/stamp memory
// access and result load; the next request is taken the cycle after the
// result is loaded, while that result may still wait at the output. An
// insert into a full cache adds a victim search: the least recently used
// slot is found by walking the stamp memory one entry per cycle through its
// single registered read port, then the last stamp read is compared, the
// walk is seen finished and the victim is written. No clearing pass is
// needed after reset or clear; valid bits live in flip-flops.
module glyph_metadata_lru_cache
  import glm_pkg::*;
#(
  parameter int SLOTS = SLOTS_DEFAULT
) (
  input wire logic clk,
  input wire logic rst,
  glm_req_if.sink  req,
  glm_rsp_if.source rsp
);

  glm_cmd_t    cmd;
  glm_status_t status;
  glm_item_t   item;
  glm_record_t rsp_rec;
  logic        rsp_hit;
  logic        rsp_valid;

  // gather the request payload into one bundle
  assign item.op              = req.op;
  assign item.codepoint       = req.codepoint;
  assign item.rec.width       = req.new_width;
  assign item.rec.height      = req.new_height;
  assign item.rec.advance     = req.new_advance;
  assign item.rec.left        = req.new_left;
  assign item.rec.top         = req.new_top;
  assign item.rec.data_length = req.new_data_length;
  assign item.rec.data_offset = req.new_data_offset;

  // sequencer: one transaction at a time
  glm_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req.valid),
    .req_ready (req.ready),
    .status    (status),
    .cmd       (cmd)
  );

  // storage, compare, victim scan and the output register
  glm_datapath #(
    .SLOTS (SLOTS)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .status    (status),
    .item      (item),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp.ready),
    .rsp_hit   (rsp_hit),
    .rsp_rec   (rsp_rec)
  );

  // result fields are zero unless a lookup hit
  assign rsp.valid             = rsp_valid;
  assign rsp.hit               = rsp_hit;
  assign rsp.glyph_width       = rsp_rec.width;
  assign rsp.glyph_height      = rsp_rec.height;
  assign rsp.glyph_advance     = rsp_rec.advance;
  assign rsp.glyph_left        = rsp_rec.left;
  assign rsp.glyph_top         = rsp_rec.top;
  assign rsp.glyph_data_length = rsp_rec.data_length;
  assign rsp.glyph_data_offset = rsp_rec.data_offset;

endmodule
`default_nettype wire
